[sv/dsa_pkg.sv]
package dsa_pkg;

    // Result field widths.
    localparam int SLOPE_W  = 15;
    localparam int ASPECT_W = 19;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    // Gradients are scaled up by this many bits before the CORDIC.
    localparam int GUARD_SHIFT = 24;

    // CORDIC gain in Q16 and its width.
    localparam int GAIN_BITS = 17;
    localparam logic [GAIN_BITS-1:0] GAIN_Q16 = 17'd107922;

    // Angle accumulator in 1/65536 degree.
    localparam int AW = 27;
    localparam logic signed [AW-1:0] DEG_90  = 27'sd5898240;
    localparam logic signed [AW-1:0] DEG_180 = 27'sd11796480;
    localparam logic signed [AW-1:0] DEG_360 = 27'sd23592960;
    localparam logic signed [AW-1:0] ROUND_HALF = 27'sd128;

    // Output limits in 1/256 degree.
    localparam logic signed [AW-1:0] ASP_MIN   = -27'sd46080;
    localparam logic signed [AW-1:0] ASP_MAX   = 27'sd138240;
    localparam logic signed [AW-1:0] ASP_FULL  = 27'sd92160;
    localparam logic signed [AW-1:0] ASP_FLAT0 = 27'sd23040;
    localparam logic signed [AW-1:0] SLOPE_MAX = 27'sd23040;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

[sv/dsa_sample_if.sv]
interface dsa_sample_if #(
    parameter int ELEV_BITS = 24
);
    logic                        valid;
    logic                        ready;
    logic signed [ELEV_BITS-1:0] elevation;
    logic                        frame_start;

    modport source (output valid, elevation, frame_start, input ready);
    modport sink (input valid, elevation, frame_start, output ready);
endinterface

[sv/dsa_result_if.sv]
interface dsa_result_if;
    import dsa_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [SLOPE_W-1:0]  slope_deg;
    logic signed [ASPECT_W-1:0] aspect_deg;
    logic                       last_in_frame;

    modport source (output valid, slope_deg, aspect_deg, last_in_frame, input ready);
    modport sink (input valid, slope_deg, aspect_deg, last_in_frame, output ready);
endinterface

[sv/dem_slope_aspect.sv]
// Slope and aspect of an elevation raster, one result per interior pixel.
// Samples enter in raster order; two line stores in block memory and a 3x3
// window hold the neighborhood, and border pixels give no result. One
// shared iterative CORDIC does both angles, one micro-rotation per cycle,
// and takes no new sample until the last is done. An interior pixel runs
// the gradient, rotation and output states, a border pixel only the read.
// A finished result waits in an output register while the next item is
// taken. The line stores need no clearing after reset.
module dem_slope_aspect #(
    parameter int MAX_WIDTH    = 2048,
    parameter int ELEV_BITS    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data,
    dsa_sample_if.sink                     samples,
    dsa_result_if.source                   results
);
    import dsa_pkg::*;

    localparam int GW  = ELEV_BITS + 3;
    localparam int SW  = GW + GUARD_SHIFT + 3;
    localparam int CW  = (SW > 49) ? SW : 49;
    localparam int MW  = (GW - 1 > 19) ? GW - 1 : 19;
    localparam int PW  = MW + GAIN_BITS;
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int WVW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int IW  = $clog2(CORDIC_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_GRAD, S_DEN, S_START, S_MAG,
        S_ITER1, S_ASP, S_ITER2, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic        method_reg;
    logic [15:0] spacing_reg;
    logic [11:0] row_width_reg;
    logic [15:0] frame_height_reg;

    // Position counters.
    logic [CB-1:0] col_count_reg;
    logic [15:0]   row_count_reg;

    // Item being worked on.
    logic signed [ELEV_BITS-1:0] elev_reg;
    logic [CB-1:0]               col_reg;
    logic                        emit_reg;
    logic                        last_reg;
    logic signed [ELEV_BITS-1:0] up1_reg;
    logic signed [ELEV_BITS-1:0] up2_reg;
    logic signed [ELEV_BITS-1:0] win_reg [3][3];

    logic signed [GW-1:0] gx_reg;
    logic signed [GW-1:0] gy_reg;
    logic signed [GW-1:0] cx_reg;
    logic signed [GW-1:0] cy_reg;
    logic signed [CW-1:0] den_reg;

    // CORDIC state.
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [AW-1:0] acc_reg;
    logic [IW-1:0]        iter_reg;

    // Output register.
    logic                       ovalid_reg;
    logic [SLOPE_W-1:0]         slope_reg;
    logic signed [ASPECT_W-1:0] aspect_reg;
    logic                       olast_reg;
    logic signed [ASPECT_W-1:0] asp_hold_reg;

    // Line stores.
    logic signed [ELEV_BITS-1:0] line0_mem [MAX_WIDTH];
    logic signed [ELEV_BITS-1:0] line1_mem [MAX_WIDTH];

    function automatic logic signed [CW-1:0] scale_g(input logic signed [GW-1:0] g);
        return CW'(g) <<< GUARD_SHIFT;
    endfunction

    // Handshake.
    logic in_acc;
    logic out_load;
    assign samples.ready         = (state_reg == S_IDLE);
    assign in_acc                = samples.valid && (state_reg == S_IDLE);
    assign out_load              = (state_reg == S_OUT) && (!ovalid_reg || results.ready);
    assign results.valid         = ovalid_reg;
    assign results.slope_deg     = slope_reg;
    assign results.aspect_deg    = aspect_reg;
    assign results.last_in_frame = olast_reg;

    // Effective row width and position of the incoming sample.
    logic [WVW-1:0] rw_ext;
    logic [WVW-1:0] w_w;
    logic [CB-1:0]  col_w;
    logic [15:0]    row_w;
    logic           wrap_w;
    logic           emit_w;
    logic           last_w;

    assign rw_ext = WVW'(row_width_reg);
    assign w_w    = (rw_ext > WVW'(MAX_WIDTH)) ? WVW'(MAX_WIDTH) :
                    (rw_ext == '0) ? WVW'(1) : rw_ext;
    assign col_w  = samples.frame_start ? '0 : col_count_reg;
    assign row_w  = samples.frame_start ? '0 : row_count_reg;
    assign wrap_w = ((WVW + 1)'(col_w) + (WVW + 1)'(1)) >= (WVW + 1)'(w_w);
    assign emit_w = (col_w >= CB'(2)) && (row_w >= 16'd2) && (row_w < frame_height_reg);
    assign last_w = (WVW'(col_w) == w_w - WVW'(1)) &&
                    ({1'b0, row_w} + 17'd1 == {1'b0, frame_height_reg});

    // Gradients from the window: row 0 is north, column 0 is west.
    logic signed [GW-1:0] gx_w;
    logic signed [GW-1:0] gy_w;

    always_comb
    begin
        if (method_reg)
        begin
            gx_w = (GW'(win_reg[0][2]) + (GW'(win_reg[1][2]) <<< 1) + GW'(win_reg[2][2]))
                 - (GW'(win_reg[0][0]) + (GW'(win_reg[1][0]) <<< 1) + GW'(win_reg[2][0]));
            gy_w = (GW'(win_reg[0][0]) + (GW'(win_reg[0][1]) <<< 1) + GW'(win_reg[0][2]))
                 - (GW'(win_reg[2][0]) + (GW'(win_reg[2][1]) <<< 1) + GW'(win_reg[2][2]));
        end
        else
        begin
            gx_w = GW'(win_reg[1][2]) - GW'(win_reg[1][0]);
            gy_w = GW'(win_reg[2][1]) - GW'(win_reg[0][1]);
        end
    end

    // Shared constant multiplier for the gain of the denominator or of an
    // on-axis magnitude.
    logic signed [GW-1:0] sel_g;
    logic [GW-1:0]        abs_g;
    logic [18:0]          kd_w;
    logic [MW-1:0]        mul_a;
    logic [PW-1:0]        prod_w;

    assign sel_g  = (cy_reg == '0) ? cx_reg : cy_reg;
    assign abs_g  = (sel_g < 0) ? GW'(-sel_g) : GW'(sel_g);
    assign kd_w   = method_reg ? {spacing_reg, 3'b000} : {2'b00, spacing_reg, 1'b0};
    assign mul_a  = (state_reg == S_DEN) ? MW'(kd_w) : MW'(abs_g[GW-2:0]);
    assign prod_w = PW'(mul_a) * PW'(GAIN_Q16);

    // One CORDIC micro-rotation.
    logic signed [CW-1:0] sx_w;
    logic signed [CW-1:0] sy_w;
    logic signed [AW-1:0] tab_w;
    logic                 iter_last;

    assign sx_w      = x_reg >>> iter_reg;
    assign sy_w      = y_reg >>> iter_reg;
    assign tab_w     = signed'(AW'(atan_entry(5'(iter_reg))));
    assign iter_last = (iter_reg == IW'(CORDIC_STEPS - 1));

    // Aspect from the finished angle, per method.
    logic signed [ASPECT_W-1:0] asp_w;

    always_comb
    begin
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] r;
        a = acc_reg;
        if (method_reg)
        begin
            if (gy_reg > 0)
                a = a + DEG_180;
            if (gy_reg < 0 && gx_reg > 0)
                a = a + DEG_360;
            r = (a + ROUND_HALF) >>> 8;
            if (r < ASP_MIN)
                r = ASP_MIN;
            if (r > ASP_MAX)
                r = ASP_MAX;
        end
        else if (gy_reg == '0)
        begin
            r = ASP_FLAT0;
        end
        else
        begin
            r = (a + ROUND_HALF) >>> 8;
            if (r < 0)
                r = r + ASP_FULL;
            if (r >= ASP_FULL)
                r = r - ASP_FULL;
            if (r < 0)
                r = '0;
        end
        asp_w = ASPECT_W'(r);
    end

    // Slope from the finished angle.
    logic [SLOPE_W-1:0] slope_w;

    always_comb
    begin
        logic signed [AW-1:0] s;
        s = (acc_reg + ROUND_HALF) >>> 8;
        if (s < 0)
            s = '0;
        if (s > SLOPE_MAX)
            s = SLOPE_MAX;
        slope_w = SLOPE_W'(s);
    end

    // Line store reads on accept and writes back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            up1_reg <= line0_mem[col_w];
            up2_reg <= line1_mem[col_w];
        end
        if (state_reg == S_READ)
        begin
            line0_mem[col_reg] <= elev_reg;
            line1_mem[col_reg] <= up1_reg;
        end
    end

    // Sequencer, configuration, window and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            method_reg       <= 1'b1;
            spacing_reg      <= 16'd100;
            row_width_reg    <= 12'd1024;
            frame_height_reg <= 16'd1024;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            elev_reg         <= '0;
            col_reg          <= '0;
            emit_reg         <= 1'b0;
            last_reg         <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
            gx_reg           <= '0;
            gy_reg           <= '0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            den_reg          <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            acc_reg          <= '0;
            iter_reg         <= '0;
            ovalid_reg       <= 1'b0;
            slope_reg        <= '0;
            aspect_reg       <= '0;
            olast_reg        <= 1'b0;
            asp_hold_reg     <= '0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_METHOD:       method_reg       <= cfg_data[0];
                    REG_SPACING:      spacing_reg      <= cfg_data;
                    REG_ROW_WIDTH:    row_width_reg    <= cfg_data[11:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end

            // The output register loads a finished item, or empties when
            // its item is taken.
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (results.ready)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        elev_reg <= samples.elevation;
                        col_reg  <= col_w;
                        emit_reg <= emit_w;
                        last_reg <= last_w;
                        if (wrap_w)
                        begin
                            col_count_reg <= '0;
                            row_count_reg <= (row_w != 16'hFFFF) ? row_w + 16'd1 : row_w;
                        end
                        else
                        begin
                            col_count_reg <= col_w + CB'(1);
                            row_count_reg <= row_w;
                        end
                        state_reg <= S_READ;
                    end
                end

                S_READ:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= up2_reg;
                    win_reg[1][2] <= up1_reg;
                    win_reg[2][2] <= elev_reg;
                    state_reg <= emit_reg ? S_GRAD : S_IDLE;
                end

                S_GRAD:
                begin
                    gx_reg <= gx_w;
                    gy_reg <= gy_w;
                    if (method_reg)
                    begin
                        cy_reg <= gx_w;
                        cx_reg <= gy_w;
                    end
                    else
                    begin
                        cy_reg <= -gx_w;
                        cx_reg <= -gy_w;
                    end
                    state_reg <= S_DEN;
                end

                S_DEN:
                begin
                    den_reg   <= signed'(CW'({prod_w, 8'd0}));
                    state_reg <= S_START;
                end

                // On-axis vectors are exact; others are turned into the
                // right half plane before the micro-rotations.
                S_START:
                begin
                    iter_reg <= '0;
                    if (cy_reg == '0)
                    begin
                        acc_reg   <= (cx_reg < 0) ? DEG_180 : '0;
                        state_reg <= S_MAG;
                    end
                    else if (cx_reg == '0)
                    begin
                        acc_reg   <= (cy_reg > 0) ? DEG_90 : -DEG_90;
                        state_reg <= S_MAG;
                    end
                    else
                    begin
                        if (cx_reg < 0)
                        begin
                            if (cy_reg > 0)
                            begin
                                x_reg   <= scale_g(cy_reg);
                                y_reg   <= scale_g(-cx_reg);
                                acc_reg <= DEG_90;
                            end
                            else
                            begin
                                x_reg   <= scale_g(-cy_reg);
                                y_reg   <= scale_g(cx_reg);
                                acc_reg <= -DEG_90;
                            end
                        end
                        else
                        begin
                            x_reg   <= scale_g(cx_reg);
                            y_reg   <= scale_g(cy_reg);
                            acc_reg <= '0;
                        end
                        state_reg <= S_ITER1;
                    end
                end

                S_MAG:
                begin
                    x_reg     <= signed'(CW'({prod_w, 8'd0}));
                    state_reg <= S_ASP;
                end

                S_ITER1, S_ITER2:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg   <= x_reg + sy_w;
                        y_reg   <= y_reg - sx_w;
                        acc_reg <= acc_reg + tab_w;
                    end
                    else
                    begin
                        x_reg   <= x_reg - sy_w;
                        y_reg   <= y_reg + sx_w;
                        acc_reg <= acc_reg - tab_w;
                    end
                    iter_reg <= iter_reg + IW'(1);
                    if (iter_last)
                        state_reg <= (state_reg == S_ITER1) ? S_ASP : S_OUT;
                end

                // Aspect is done; the slope takes the gained magnitude
                // against the gained denominator.
                S_ASP:
                begin
                    asp_hold_reg <= asp_w;
                    iter_reg     <= '0;
                    if (x_reg == '0)
                    begin
                        acc_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (den_reg == '0)
                    begin
                        acc_reg   <= DEG_90;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        y_reg     <= x_reg;
                        x_reg     <= den_reg;
                        acc_reg   <= '0;
                        state_reg <= S_ITER2;
                    end
                end

                S_OUT:
                begin
                    if (out_load)
                    begin
                        slope_reg  <= slope_w;
                        aspect_reg <= asp_hold_reg;
                        olast_reg  <= last_reg;
                        state_reg  <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
